// ===== rtl/core/bhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared types, sizes and helpers for the binary heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package bhpq_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	// child index 2*pos+2 needs two bits more than a slot index
	localparam int CH_W     = IDX_W + 2;
	localparam int ENTRY_W  = 64;
	localparam int OUT_RAW_W = ENTRY_W + CNT_W + 1;
	localparam int OUT_W    = 8 * ((OUT_RAW_W + 7) / 8);

	typedef struct packed {
		logic [15:0] tag;
		logic [15:0] prio;
		logic [31:0] time_key;
	} entry_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_POP    = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_POP_LD,
		S_DN_RD,
		S_DN_CMP,
		S_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic    load_ins;   // latch new entry, open hole at the tail
		logic    load_pop;   // shrink, read root and last entry
		logic    load_err;   // refused transaction, result is zeros
		status_t err_code;
		logic    rd_parent;
		logic    rd_child;
		logic    pop_ld;     // root to result, last entry to hold
		logic    wr_hold;    // place held entry in the hole
		logic    up_move;    // parent drops into the hole
		logic    dn_move;    // chosen child rises into the hole
		logic    out_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full;
		logic empty;
		logic pos_zero;
		logic up_move;
		logic dn_leaf;
		logic dn_move;
		logic out_busy;
	} stat_t;

	// true when a must sit below b: later time, or same time and lower priority
	function automatic logic sits_below(entry_t a, entry_t b);
		logic res;
		if (a.time_key != b.time_key) begin
			res = a.time_key > b.time_key;
		end else begin
			res = a.prio < b.prio;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bhpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bhpq_ctrl
// Sequencer for insert/pop: sift up or sift down one level per read state and compare state.
// ----------------------------------------------------------------------------
`default_nettype none

module bhpq_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic            in_op,
	output logic                 in_ready,
	input  bhpq_pkg::stat_t      stat,
	output bhpq_pkg::cmd_t       cmd
);

	bhpq_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bhpq_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		cmd.err_code = bhpq_pkg::ST_OK;
		in_ready = 1'b0;
		unique case (state_q)
			bhpq_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op == bhpq_pkg::OP_INSERT) begin
						if (stat.full) begin
							cmd.load_err = 1'b1;
							cmd.err_code = bhpq_pkg::ST_FULL;
							state_nx     = bhpq_pkg::S_FINISH;
						end else begin
							cmd.load_ins = 1'b1;
							state_nx     = bhpq_pkg::S_INS_RD;
						end
					end else begin
						if (stat.empty) begin
							cmd.load_err = 1'b1;
							cmd.err_code = bhpq_pkg::ST_EMPTY;
							state_nx     = bhpq_pkg::S_FINISH;
						end else begin
							cmd.load_pop = 1'b1;
							state_nx     = bhpq_pkg::S_POP_LD;
						end
					end
				end
			end
			bhpq_pkg::S_INS_RD: begin
				if (stat.pos_zero) begin
					cmd.wr_hold = 1'b1;
					state_nx    = bhpq_pkg::S_FINISH;
				end else begin
					cmd.rd_parent = 1'b1;
					state_nx      = bhpq_pkg::S_INS_CMP;
				end
			end
			bhpq_pkg::S_INS_CMP: begin
				if (stat.up_move) begin
					cmd.up_move = 1'b1;
					state_nx    = bhpq_pkg::S_INS_RD;
				end else begin
					cmd.wr_hold = 1'b1;
					state_nx    = bhpq_pkg::S_FINISH;
				end
			end
			bhpq_pkg::S_POP_LD: begin
				cmd.pop_ld = 1'b1;
				state_nx   = bhpq_pkg::S_DN_RD;
			end
			bhpq_pkg::S_DN_RD: begin
				if (stat.dn_leaf) begin
					cmd.wr_hold = 1'b1;
					state_nx    = bhpq_pkg::S_FINISH;
				end else begin
					cmd.rd_child = 1'b1;
					state_nx     = bhpq_pkg::S_DN_CMP;
				end
			end
			bhpq_pkg::S_DN_CMP: begin
				if (stat.dn_move) begin
					cmd.dn_move = 1'b1;
					state_nx    = bhpq_pkg::S_DN_RD;
				end else begin
					cmd.wr_hold = 1'b1;
					state_nx    = bhpq_pkg::S_FINISH;
				end
			end
			bhpq_pkg::S_FINISH: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_nx     = bhpq_pkg::S_IDLE;
				end
			end
			default: state_nx = bhpq_pkg::S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/bhpq_dp.sv =====
// ----------------------------------------------------------------------------
// bhpq_dp
// Heap store, hole position, held entry, fill count and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bhpq_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  bhpq_pkg::entry_t                   in_entry,
	input  bhpq_pkg::cmd_t                     cmd,
	output bhpq_pkg::stat_t                    stat,
	input  wire logic                          out_ready,
	output logic                               out_valid,
	output bhpq_pkg::status_t                  out_status,
	output bhpq_pkg::entry_t                   out_entry,
	output logic [bhpq_pkg::CNT_W-1:0]         out_count,
	output logic                               out_empty
);

	bhpq_pkg::entry_t mem [bhpq_pkg::CAPACITY];

	bhpq_pkg::entry_t                  hold_q, rd_a_q, rd_b_q, res_entry_q;
	bhpq_pkg::status_t                 res_status_q;
	logic [bhpq_pkg::IDX_W-1:0]        pos_q;
	logic [bhpq_pkg::CNT_W-1:0]        fill_q;
	logic                              out_valid_q;

	logic [bhpq_pkg::IDX_W-1:0]        parent_idx, raddr_a, raddr_b, waddr;
	logic [bhpq_pkg::CNT_W-1:0]        last_cnt;
	logic [bhpq_pkg::CH_W-1:0]         l_idx, r_idx, fill_ch;
	logic                              r_valid, pick_r, we;
	bhpq_pkg::entry_t                  child, wdata;
	logic [bhpq_pkg::IDX_W-1:0]        child_idx;

	assign parent_idx = bhpq_pkg::IDX_W'((pos_q - bhpq_pkg::IDX_W'(1)) >> 1);
	assign last_cnt   = fill_q - bhpq_pkg::CNT_W'(1);
	assign l_idx      = bhpq_pkg::CH_W'({pos_q, 1'b1});
	assign r_idx      = l_idx + bhpq_pkg::CH_W'(1);
	assign fill_ch    = bhpq_pkg::CH_W'(fill_q);
	assign r_valid    = r_idx < fill_ch;
	assign pick_r     = r_valid && bhpq_pkg::sits_below(rd_a_q, rd_b_q);
	assign child      = pick_r ? rd_b_q : rd_a_q;
	assign child_idx  = pick_r ? r_idx[bhpq_pkg::IDX_W-1:0] : l_idx[bhpq_pkg::IDX_W-1:0];

	// read address select: pop start reads root and tail, sift down both children, else the parent
	always_comb begin
		if (cmd.load_pop) begin
			raddr_a = '0;
			raddr_b = last_cnt[bhpq_pkg::IDX_W-1:0];
		end else if (cmd.rd_child) begin
			raddr_a = l_idx[bhpq_pkg::IDX_W-1:0];
			raddr_b = r_idx[bhpq_pkg::IDX_W-1:0];
		end else begin
			raddr_a = parent_idx;
			raddr_b = parent_idx;
		end
	end

	always_comb begin
		we    = cmd.wr_hold | cmd.up_move | cmd.dn_move;
		waddr = pos_q;
		if (cmd.up_move) begin
			wdata = rd_a_q;
		end else if (cmd.dn_move) begin
			wdata = child;
		end else begin
			wdata = hold_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.load_pop || cmd.rd_child || cmd.rd_parent) begin
			rd_a_q <= mem[raddr_a];
			rd_b_q <= mem[raddr_b];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_ins) begin
			hold_q <= in_entry;
			pos_q  <= fill_q[bhpq_pkg::IDX_W-1:0];
		end else if (cmd.pop_ld) begin
			hold_q <= rd_b_q;
			pos_q  <= '0;
		end else if (cmd.up_move) begin
			pos_q  <= parent_idx;
		end else if (cmd.dn_move) begin
			pos_q  <= child_idx;
		end

		if (cmd.load_ins || cmd.load_pop || cmd.load_err) begin
			res_entry_q  <= '0;
			res_status_q <= cmd.load_err ? cmd.err_code : bhpq_pkg::ST_OK;
		end else if (cmd.pop_ld) begin
			res_entry_q  <= rd_a_q;
		end

		if (cmd.out_load) begin
			out_status <= res_status_q;
			out_entry  <= res_entry_q;
			out_count  <= fill_q;
			out_empty  <= (fill_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_ins) begin
				fill_q <= fill_q + bhpq_pkg::CNT_W'(1);
			end else if (cmd.load_pop) begin
				fill_q <= last_cnt;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign stat.full      = (fill_q == bhpq_pkg::CNT_W'(bhpq_pkg::CAPACITY));
	assign stat.empty     = (fill_q == '0);
	assign stat.pos_zero  = (pos_q == '0);
	assign stat.up_move   = bhpq_pkg::sits_below(rd_a_q, hold_q);
	assign stat.dn_leaf   = !(l_idx < fill_ch);
	assign stat.dn_move   = bhpq_pkg::sits_below(hold_q, child);
	assign stat.out_busy  = out_valid_q && !out_ready;

endmodule

`default_nettype wire

// ===== rtl/core/binary_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// Min-heap priority queue: earliest time first, higher priority on a tie.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake          Payload
//  s_*      in   s_tvalid/s_tready  tuser: operation; tdata: time, prio, tag
//  m_*      out  m_tvalid/m_tready  tuser: status; tdata: time, prio, tag,
//                                   entry_count, heap_empty
//
//  One transaction in at a time. Each sift level is a read of the heap store
//  (registered) then a compare and one write. Insert sifts up from the tail,
//  pop moves the last entry to the root and sifts it down; refused
//  transactions (full/empty) go straight to the result step.
//  arst_n clears the fill count and the controller; the store is not cleared.
//  A new input is taken while the previous result waits in the output
//  register; the sequencer only stalls at its last step if it is still held.
//
`default_nettype none

module binary_heap_priority_queue (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	// [31:0] entry_time, [47:32] entry_priority, [63:48] entry_tag
	input  wire logic [63:0]                 s_tdata,
	// [0] operation
	input  wire logic [0:0]                  s_tuser,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// [31:0] out_time, [47:32] out_priority, [63:48] out_tag,
	// [CNT_W+63:64] entry_count, next bit heap_empty, rest zero
	output logic [bhpq_pkg::OUT_W-1:0]       m_tdata,
	// [1:0] status
	output logic [1:0]                       m_tuser
);

	bhpq_pkg::cmd_t               cmd;
	bhpq_pkg::stat_t              stat;
	bhpq_pkg::entry_t             in_entry, out_entry;
	bhpq_pkg::status_t            out_status;
	logic [bhpq_pkg::CNT_W-1:0]   out_count;
	logic                         out_empty;

	// unpack input fields
	assign in_entry.time_key = s_tdata[31:0];
	assign in_entry.prio     = s_tdata[47:32];
	assign in_entry.tag      = s_tdata[63:48];

	bhpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_op    (s_tuser[0]),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bhpq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_entry   (in_entry),
		.cmd        (cmd),
		.stat       (stat),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_status (out_status),
		.out_entry  (out_entry),
		.out_count  (out_count),
		.out_empty  (out_empty)
	);

	// pack result fields, zero fill to a byte boundary
	assign m_tdata = bhpq_pkg::OUT_W'({out_empty, out_count, out_entry.tag,
	                                   out_entry.prio, out_entry.time_key});
	assign m_tuser = out_status;

endmodule

`default_nettype wire

// ===== rtl/core/bhpq_checker.sv =====
// ----------------------------------------------------------------------------
// bhpq_checker
// Port-level checks for the heap queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bhpq_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       s_tvalid,
	input wire logic                       s_tready,
	input wire logic [63:0]                s_tdata,
	input wire logic [0:0]                 s_tuser,
	input wire logic                       m_tvalid,
	input wire logic                       m_tready,
	input wire logic [bhpq_pkg::OUT_W-1:0] m_tdata,
	input wire logic [1:0]                 m_tuser
);

	localparam int CNT_LO = 64;
	localparam int CNT_HI = 64 + bhpq_pkg::CNT_W - 1;
	localparam int EMP_B  = 64 + bhpq_pkg::CNT_W;

	// held result must not change while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one transaction at a time
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken twice in a row");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[EMP_B] == (m_tdata[CNT_HI:CNT_LO] == '0))
		else $error("empty flag disagrees with count");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == bhpq_pkg::ST_FULL |->
		m_tdata[CNT_HI:CNT_LO] == bhpq_pkg::CNT_W'(bhpq_pkg::CAPACITY))
		else $error("full refusal with free slots");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == bhpq_pkg::ST_EMPTY |->
		m_tdata[EMP_B] && m_tdata[63:0] == '0)
		else $error("empty pop returned data");

endmodule

bind binary_heap_priority_queue bhpq_checker u_bhpq_checker (.*);

`default_nettype wire
